FILE: rtl/scv_pkg.sv
package scv_pkg;

    // Argument limits
    localparam int unsigned MAX_DIGITS = 7;
    localparam logic [3:0]  COUNT_SAT  = 4'd9;
    localparam logic [3:0]  COUNT_MAX  = 4'(MAX_DIGITS + 1);
    localparam logic [23:0] ACC_SAT    = 24'd9999999;
    localparam logic [23:0] VALUE_MAX  = 24'd32767;
    localparam logic [15:0] MS_SCALE   = 16'd1000;

    // Command letters, ASCII
    localparam logic [7:0] CH_V    = 8'h76;
    localparam logic [7:0] CH_S    = 8'h73;
    localparam logic [7:0] CH_G    = 8'h67;
    localparam logic [7:0] CH_D    = 8'h64;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] CH_M    = 8'h6D;
    localparam logic [7:0] CH_L    = 8'h6C;
    localparam logic [7:0] CH_T    = 8'h74;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_EMPTY     = 3'd1;
    localparam logic [2:0] ERR_UNKNOWN   = 3'd2;
    localparam logic [2:0] ERR_NO_ARG    = 3'd3;
    localparam logic [2:0] ERR_NON_NUM   = 3'd4;
    localparam logic [2:0] ERR_TOO_LONG  = 3'd5;
    localparam logic [2:0] ERR_RANGE     = 3'd6;
    localparam logic [2:0] ERR_NO_WRAP   = 3'd7;

    // Per-command parse state
    typedef struct packed {
        logic [7:0]  head_char;
        logic [3:0]  char_count;
        logic        digits_only;
        logic [23:0] acc_value;
    } t_state;

    localparam t_state STATE_RESET = '{
        head_char:   8'd0,
        char_count:  4'd0,
        digits_only: 1'b1,
        acc_value:   24'd0
    };

    // One result item
    typedef struct packed {
        logic               ok;
        logic [2:0]         error_code;
        logic [23:0]        arg_value;
        logic signed [15:0] wrapped_ms;
    } t_result;

    // Letters accepted without an argument
    function automatic logic is_lone_letter(input logic [7:0] c);
        return (c == CH_V) || (c == CH_S) || (c == CH_G) ||
               (c == CH_D) || (c == CH_X) || (c == CH_M);
    endfunction

endpackage

FILE: rtl/scv_if.sv
// Command character channel
interface scv_cmd_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;
    logic       empty_cmd;

    modport source (output valid, output ch, output last, output empty_cmd, input ready);
    modport sink   (input valid, input ch, input last, input empty_cmd, output ready);
endinterface

// Verdict channel
interface scv_res_if;
    logic               valid;
    logic               ready;
    logic               ok;
    logic [2:0]         error_code;
    logic [23:0]        arg_value;
    logic signed [15:0] wrapped_ms;

    modport source (output valid, output ok, output error_code, output arg_value,
                    output wrapped_ms, input ready);
    modport sink   (input valid, input ok, input error_code, input arg_value,
                    input wrapped_ms, output ready);
endinterface

FILE: rtl/serial_command_validator_unit.sv
// A command's final item is held in the input register, then its verdict in the result register.
// Throughput: one character item per cycle unless a final item waits on a pending verdict; the input
// register and the result register let a new item enter while a verdict waits to be taken.
// Reset: synchronous, active low; clears the handshake flags and the parse state.
module serial_command_validator_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    scv_cmd_if.sink          i_cmd,
    scv_res_if.source        o_res
);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_ch;
    logic       r_in_last;
    logic       r_in_empty;

    // Parse state and result register
    scv_pkg::t_state  r_state;
    scv_pkg::t_state  n_state;
    scv_pkg::t_state  step_next;
    scv_pkg::t_result step_result;
    scv_pkg::t_result n_result;
    scv_pkg::t_result r_result;
    logic             r_out_valid;

    logic out_free;
    logic produces;
    logic proc_go;
    logic in_take;

    assign out_free = !r_out_valid || o_res.ready;
    assign produces = r_in_empty || r_in_last;
    assign proc_go  = r_in_valid && (!produces || out_free);
    assign in_take  = i_cmd.valid && i_cmd.ready;

    assign i_cmd.ready = !r_in_valid || proc_go;

    scv_step u_step (
        .i_state  (r_state),
        .i_ch     (r_in_ch),
        .o_next   (step_next),
        .o_result (step_result)
    );

    // Next state and verdict; an empty command overrides everything
    always_comb begin
        n_state  = r_state;
        n_result = step_result;
        if (proc_go) begin
            if (r_in_empty) begin
                n_state  = scv_pkg::STATE_RESET;
                n_result = '{ok: 1'b0, error_code: scv_pkg::ERR_EMPTY,
                             arg_value: 24'd0, wrapped_ms: 16'sd0};
            end else if (r_in_last) begin
                n_state = scv_pkg::STATE_RESET;
            end else begin
                n_state = step_next;
            end
        end
    end

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
        if (in_take) begin
            r_in_ch    <= i_cmd.ch;
            r_in_last  <= i_cmd.last;
            r_in_empty <= i_cmd.empty_cmd;
        end
    end

    // Parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scv_pkg::STATE_RESET;
        end else begin
            r_state <= n_state;
        end
    end

    // Result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= proc_go && produces;
        end
        if (proc_go && produces) begin
            r_result <= n_result;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.ok         = r_result.ok;
    assign o_res.error_code = r_result.error_code;
    assign o_res.arg_value  = r_result.arg_value;
    assign o_res.wrapped_ms = r_result.wrapped_ms;

    // A passing verdict carries no error code, a failing one always does
    a_ok_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.ok == (o_res.error_code == scv_pkg::ERR_NONE)))
        else $error("verdict flag and error code disagree");

    // Rejected before the wrap check means no argument is reported
    a_no_arg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.error_code != scv_pkg::ERR_NONE) &&
         (o_res.error_code != scv_pkg::ERR_NO_WRAP))
        |-> ((o_res.arg_value == 24'd0) && (o_res.wrapped_ms == 16'sd0)))
        else $error("argument reported on an early rejection");

    // A finished command leaves the parse state cleared
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_go && produces) |=> ((r_state.char_count == 4'd0) &&
                                   (r_state.acc_value == 24'd0) && r_state.digits_only))
        else $error("parse state not cleared after a verdict");

    // A verdict issued only when the output side could take it
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_go && produces) |-> out_free)
        else $error("verdict would overwrite a pending result");

endmodule

FILE: rtl/scv_step.sv
// Folds one character into the parse state and judges the updated state
module scv_step (
    input  scv_pkg::t_state  i_state,
    input  logic [7:0]       i_ch,
    output scv_pkg::t_state  o_next,
    output scv_pkg::t_result o_result
);

    logic        is_digit;
    logic [27:0] acc_ext;
    logic [27:0] acc_sum;
    logic [31:0] ms_prod;
    logic [15:0] ms_low;

    assign is_digit = (i_ch >= scv_pkg::CH_ZERO) && (i_ch <= scv_pkg::CH_NINE);

    // acc * 10 + digit, the digit being the low nibble of an ASCII digit
    assign acc_ext = {4'd0, i_state.acc_value};
    assign acc_sum = (acc_ext << 3) + (acc_ext << 1) + {24'd0, i_ch[3:0]};

    // State update
    always_comb begin
        o_next = i_state;
        if (i_state.char_count == 4'd0) begin
            o_next.head_char = i_ch;
        end else if (!is_digit) begin
            o_next.digits_only = 1'b0;
        end else if (acc_sum > {4'd0, scv_pkg::ACC_SAT}) begin
            o_next.acc_value = scv_pkg::ACC_SAT;
        end else begin
            o_next.acc_value = acc_sum[23:0];
        end
        if (i_state.char_count < scv_pkg::COUNT_SAT) begin
            o_next.char_count = i_state.char_count + 4'd1;
        end
    end

    // Value in ms, wrapped to 16 bits; only the low 16 bits of the argument matter
    assign ms_prod = {16'd0, o_next.acc_value[15:0]} * {16'd0, scv_pkg::MS_SCALE};
    assign ms_low  = ms_prod[15:0];

    // Verdict on the updated state, first failing rule wins
    always_comb begin
        o_result = '{ok: 1'b0, error_code: scv_pkg::ERR_NONE,
                     arg_value: 24'd0, wrapped_ms: 16'sd0};
        priority if (o_next.char_count == 4'd1) begin
            if (scv_pkg::is_lone_letter(o_next.head_char)) begin
                o_result.ok = 1'b1;
            end else begin
                o_result.error_code = scv_pkg::ERR_UNKNOWN;
            end
        end else if ((o_next.head_char != scv_pkg::CH_L) &&
                     (o_next.head_char != scv_pkg::CH_T)) begin
            o_result.error_code = scv_pkg::ERR_NO_ARG;
        end else if (!o_next.digits_only) begin
            o_result.error_code = scv_pkg::ERR_NON_NUM;
        end else if (o_next.char_count > scv_pkg::COUNT_MAX) begin
            o_result.error_code = scv_pkg::ERR_TOO_LONG;
        end else if ((o_next.acc_value == 24'd0) ||
                     (o_next.acc_value > scv_pkg::VALUE_MAX)) begin
            o_result.error_code = scv_pkg::ERR_RANGE;
        end else if (o_next.head_char == scv_pkg::CH_T) begin
            o_result.arg_value  = o_next.acc_value;
            o_result.wrapped_ms = $signed(ms_low);
            if (ms_low[15]) begin
                o_result.ok = 1'b1;
            end else begin
                o_result.error_code = scv_pkg::ERR_NO_WRAP;
            end
        end else begin
            o_result.ok        = 1'b1;
            o_result.arg_value = o_next.acc_value;
        end
    end

endmodule

FILE: bench/command_verdict_checker.sv
`timescale 1ns / 1ps

// Watches both channels, predicts the verdict of every command and compares it
// with what the unit hands out.
module command_verdict_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    scv_cmd_if   i_cmd,
    scv_res_if   i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_verdict_count,
    output int   o_ok_count
);

    scv_pkg::t_result verdicts_due[$];
    scv_pkg::t_state  parse_st = scv_pkg::STATE_RESET;
    scv_pkg::t_result want;
    scv_pkg::t_result seen;
    int               mismatches = 0;
    int               verdicts = 0;
    int               accepted = 0;

    // Fold one character into the parse state
    function automatic scv_pkg::t_state absorb_char(input scv_pkg::t_state st,
                                                    input logic [7:0] c);
        scv_pkg::t_state nx;
        logic [27:0]     grown;
        nx = st;
        if (st.char_count == 4'd0) begin
            nx.head_char = c;
        end else if (c < scv_pkg::CH_ZERO || c > scv_pkg::CH_NINE) begin
            nx.digits_only = 1'b0;
        end else begin
            grown = 28'(st.acc_value) * 28'd10 + (28'(c) - 28'(scv_pkg::CH_ZERO));
            nx.acc_value = (grown > 28'(scv_pkg::ACC_SAT)) ? scv_pkg::ACC_SAT : grown[23:0];
        end
        if (st.char_count < scv_pkg::COUNT_SAT) begin
            nx.char_count = st.char_count + 4'd1;
        end
        return nx;
    endfunction

    // Verdict for a finished command; the first failing rule wins
    function automatic scv_pkg::t_result judge_command(input scv_pkg::t_state st);
        scv_pkg::t_result v;
        logic [31:0]      scaled;
        v = '0;
        if (st.char_count == 4'd1) begin
            case (st.head_char)
                scv_pkg::CH_V, scv_pkg::CH_S, scv_pkg::CH_G,
                scv_pkg::CH_D, scv_pkg::CH_X, scv_pkg::CH_M: v.ok = 1'b1;
                default: v.error_code = scv_pkg::ERR_UNKNOWN;
            endcase
        end else if (st.head_char != scv_pkg::CH_L && st.head_char != scv_pkg::CH_T) begin
            v.error_code = scv_pkg::ERR_NO_ARG;
        end else if (!st.digits_only) begin
            v.error_code = scv_pkg::ERR_NON_NUM;
        end else if (int'(st.char_count) - 1 > int'(scv_pkg::MAX_DIGITS)) begin
            v.error_code = scv_pkg::ERR_TOO_LONG;
        end else if (st.acc_value == 24'd0 || st.acc_value > scv_pkg::VALUE_MAX) begin
            v.error_code = scv_pkg::ERR_RANGE;
        end else begin
            v.arg_value = st.acc_value;
            v.ok = 1'b1;
            if (st.head_char == scv_pkg::CH_T) begin
                // value in ms, wrapped to 16 bits: only a negative wrap is accepted
                scaled = 32'(st.acc_value) * 32'(scv_pkg::MS_SCALE);
                v.wrapped_ms = scaled[15:0];
                if (!scaled[15]) begin
                    v.ok = 1'b0;
                    v.error_code = scv_pkg::ERR_NO_WRAP;
                end
            end
        end
        return v;
    endfunction

    // Sample both channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            parse_st = scv_pkg::STATE_RESET;
            verdicts_due.delete();
        end else begin
            // verdict side: check against the oldest expectation
            if (i_res.valid && i_res.ready) begin
                seen.ok = i_res.ok;
                seen.error_code = i_res.error_code;
                seen.arg_value = i_res.arg_value;
                seen.wrapped_ms = i_res.wrapped_ms;
                verdicts++;
                if (seen.ok === 1'b1) accepted++;
                if (verdicts_due.size() == 0) begin
                    $error("verdict with none expected: ok %0d, error_code %0d",
                           seen.ok, seen.error_code);
                    mismatches++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (seen.ok !== want.ok) begin
                        $error("ok: expected %0d, actual %0d", want.ok, seen.ok);
                        mismatches++;
                    end
                    if (seen.error_code !== want.error_code) begin
                        $error("error_code: expected %0d, actual %0d",
                               want.error_code, seen.error_code);
                        mismatches++;
                    end
                    if (seen.arg_value !== want.arg_value) begin
                        $error("arg_value: expected %0d, actual %0d",
                               want.arg_value, seen.arg_value);
                        mismatches++;
                    end
                    if (seen.wrapped_ms !== want.wrapped_ms) begin
                        $error("wrapped_ms: expected %0d, actual %0d",
                               want.wrapped_ms, seen.wrapped_ms);
                        mismatches++;
                    end
                end
            end
            // character side: update the parse and queue a verdict when a command ends
            if (i_cmd.valid && i_cmd.ready) begin
                if (i_cmd.empty_cmd) begin
                    want = '0;
                    want.error_code = scv_pkg::ERR_EMPTY;
                    verdicts_due = {verdicts_due, want};
                    parse_st = scv_pkg::STATE_RESET;
                end else begin
                    parse_st = absorb_char(parse_st, i_cmd.ch);
                    if (i_cmd.last) begin
                        verdicts_due = {verdicts_due, judge_command(parse_st)};
                        parse_st = scv_pkg::STATE_RESET;
                    end
                end
            end
        end
        o_pending       <= verdicts_due.size();
        o_fail_count    <= mismatches;
        o_verdict_count <= verdicts;
        o_ok_count      <= accepted;
    end

endmodule

FILE: bench/tb_serial_command_validator_unit.sv
`timescale 1ns / 1ps

module tb_serial_command_validator_unit;

    localparam int ITEM_TARGET = 1900;
    localparam int QUIET_FROM  = 1650;
    localparam int PAUSE_AT    = 1000;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    scv_cmd_if cmd_ch();
    scv_res_if res_ch();

    int fail_count;
    int pending;
    int verdict_count;
    int ok_count;

    int items_sent = 0;
    int commands_sent = 0;
    int gap_odds = 0;
    int stall_odds = 0;
    int stall_left = 0;
    int cycles = 0;
    int next_shuffle = 0;
    bit paused = 1'b0;

    logic [7:0] cmd_text[$];

    serial_command_validator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    command_verdict_checker verdict_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd_ch),
        .i_res           (res_ch),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_verdict_count (verdict_count),
        .o_ok_count      (ok_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Verdict receiver: random stall bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            res_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            res_ch.ready <= 1'b0;
            stall_left <= $urandom_range(1, 18) - 1;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // One character item; valid stays high unless an idle burst follows
    task automatic send_item(input logic [7:0] c, input logic is_last, input logic is_empty);
        cmd_ch.valid     <= 1'b1;
        cmd_ch.ch        <= c;
        cmd_ch.last      <= is_last;
        cmd_ch.empty_cmd <= is_empty;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        items_sent++;
        if (is_last || is_empty) commands_sent++;
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic send_text();
        for (int i = 0; i < cmd_text.size(); i++) begin
            send_item(cmd_text[i], i == cmd_text.size() - 1, 1'b0);
        end
    endtask

    task automatic send_word(input string s);
        cmd_text.delete();
        for (int i = 0; i < s.len(); i++) cmd_text = {cmd_text, 8'(s[i])};
        send_text();
    endtask

    function automatic logic [7:0] any_letter();
        case ($urandom_range(0, 7))
            0: return scv_pkg::CH_V;
            1: return scv_pkg::CH_S;
            2: return scv_pkg::CH_G;
            3: return scv_pkg::CH_D;
            4: return scv_pkg::CH_X;
            5: return scv_pkg::CH_M;
            6: return scv_pkg::CH_L;
            default: return scv_pkg::CH_T;
        endcase
    endfunction

    // Decimal argument: mostly in range, some small, some just past the limit,
    // some long enough to saturate the count and the value
    task automatic append_argument();
        int    pick;
        int    zeros;
        string s;
        pick = $urandom_range(0, 19);
        if (pick < 12) begin
            s = $sformatf("%0d", $urandom_range(1, 32767));
        end else if (pick < 15) begin
            s = $sformatf("%0d", $urandom_range(0, 99));
        end else if (pick < 18) begin
            s = $sformatf("%0d", $urandom_range(32760, 99999));
        end else begin
            s = "";
            repeat ($urandom_range(8, 12)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        end
        zeros = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
        repeat (zeros) cmd_text = {cmd_text, scv_pkg::CH_ZERO};
        for (int i = 0; i < s.len(); i++) cmd_text = {cmd_text, 8'(s[i])};
    endtask

    task automatic random_command();
        int         kind;
        logic [7:0] bad;
        logic [7:0] head;
        kind = $urandom_range(0, 99);
        cmd_text.delete();
        if (kind < 6) begin
            // empty command, sometimes cutting off a partial one
            repeat ($urandom_range(0, 3)) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end else begin
            if (kind < 22) begin
                head = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : any_letter();
                cmd_text = {cmd_text, head};
            end else if (kind < 84) begin
                if ($urandom_range(0, 9) == 0) head = any_letter();
                else head = $urandom_range(0, 1) ? scv_pkg::CH_T : scv_pkg::CH_L;
                cmd_text = {cmd_text, head};
                append_argument();
                // non-digit somewhere in the argument
                if (kind >= 72) begin
                    bad = 8'($urandom_range(0, 245));
                    if (bad >= scv_pkg::CH_ZERO) bad = bad + 8'd10;
                    cmd_text[$urandom_range(1, cmd_text.size() - 1)] = bad;
                end
            end else if (kind < 92) begin
                head = $urandom_range(0, 1) ? any_letter() : 8'($urandom_range(0, 255));
                cmd_text = {cmd_text, head};
                append_argument();
            end else begin
                repeat ($urandom_range(1, 10)) cmd_text = {cmd_text, 8'($urandom_range(0, 255))};
            end
            send_text();
        end
    endtask

    // Stimulus and verdict
    initial begin
        i_rst_n          <= 1'b0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.ch        <= 8'd0;
        cmd_ch.last      <= 1'b0;
        cmd_ch.empty_cmd <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every error code but the too-long one, both wrap outcomes, empty mid-command
        gap_odds = 4;
        stall_odds = 4;
        send_item(8'hFF, 1'b0, 1'b1);
        send_word("v");
        send_word("q");
        send_word("l5");
        send_word("t33");
        send_word("t1");
        send_word("sx");
        send_word("l1a");
        send_word("l0");
        send_word("l99999");
        send_item(scv_pkg::CH_L, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);

        // random commands
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= QUIET_FROM) begin
                gap_odds = 0;
                stall_odds = 0;
            end else if (items_sent >= next_shuffle) begin
                next_shuffle = items_sent + 150;
                case ($urandom_range(0, 3))
                    0: gap_odds = 0;
                    1: gap_odds = 3;
                    2: gap_odds = 8;
                    default: gap_odds = 25;
                endcase
                case ($urandom_range(0, 3))
                    0: stall_odds = 0;
                    1: stall_odds = 3;
                    2: stall_odds = 8;
                    default: stall_odds = 25;
                endcase
            end
            // hold the sender until every verdict is in
            if (!paused && items_sent >= PAUSE_AT) begin
                paused = 1'b1;
                cmd_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            random_command();
        end

        // drain
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Checked %0d verdicts (%0d accepted) from %0d commands, %0d characters",
                 verdict_count, ok_count, commands_sent, items_sent);
        $display("Mix: empty, lone letters, l/t arguments to the digit limit and past it, %s",
                 "non-digits, range and wrap cases, under random stalls");
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/scv_pkg.sv
rtl/scv_if.sv
rtl/scv_step.sv
rtl/serial_command_validator_unit.sv
bench/command_verdict_checker.sv
bench/tb_serial_command_validator_unit.sv
